### rtl/core/drnd_pkg.sv
// drnd_pkg: types, constants and the word mixing function of the deadbeef generator
// depends on nothing; imported by deadbeef_random_with_modulo_top
package drnd_pkg;

  localparam int unsigned RangeW = 31;
  localparam int unsigned TrashW = 8;
  localparam int unsigned WordW  = 32;
  localparam int unsigned CntW   = 5;

  localparam logic [WordW-1:0] SeedReset = 32'hbeefcafe;
  localparam logic [WordW-1:0] BeefReset = 32'hdeadbeef;
  localparam logic [CntW-1:0]  DivLast   = CntW'(RangeW - 1);

  localparam logic ActDraw = 1'b0;
  localparam logic ActStir = 1'b1;

  typedef struct packed {
    logic              action;
    logic [RangeW-1:0] range;
    logic [TrashW-1:0] trash;
  } drnd_in_t;

  typedef struct packed {
    logic [RangeW-1:0] value;
    logic              range_error;
  } drnd_out_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_FIN
  } drnd_state_t;

  // (w << 7) xor ((w >> 25) + add), all modulo 2^32
  function automatic logic [WordW-1:0] mix_word(input logic [WordW-1:0] w,
                                                input logic [WordW-1:0] add);
    logic [WordW-1:0] hi;
    hi = {25'd0, w[WordW-1:25]} + add;
    return {w[WordW-8:0], 7'd0} ^ hi;
  endfunction

endpackage

### rtl/core/deadbeef_random_with_modulo_top.sv
// deadbeef_random_with_modulo_top: deadbeef pseudo-random generator with a bit-serial modulo
// depends on drnd_pkg (types, reset constants, mix_word)
//
// usage
//   input channel  (in_valid / in_stall / in_data): one beat is either a draw
//   (action = 0) carrying a range, or a stir (action = 1) carrying a trash byte
//   output channel (out_valid / out_stall / out_data): one beat per draw, holding
//   value = (low 31 bits of the new seed) mod range, and range_error
//   a stir is absorbed in its accept cycle and gives no output beat
// timing
//   a draw runs through the accept cycle (both words are mixed there), then
//   a restoring remainder loop (ST_DIV), one step per dividend bit, that brings in one dividend bit per
//   cycle through a single 32-bit compare and subtract, and then ST_FIN, which loads
//   the output register; in_stall is high in ST_DIV and ST_FIN after acceptance
//   a stir completes in its accept cycle, so stirs can arrive back to back
// reset
//   rst_n low (synchronous) loads seed 0xbeefcafe and beef 0xdeadbeef and empties
//   the output register
// backpressure
//   the output register holds a finished beat while out_stall is high; the next
//   item is still taken, and a following draw waits in its final cycle until the
//   output register is free
// a zero range gives value 0 with range_error set; seed and beef still advance
module deadbeef_random_with_modulo_top (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  drnd_pkg::drnd_in_t in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output drnd_pkg::drnd_out_t out_data
);
  import drnd_pkg::*;

  // control state
  drnd_state_t       state_r, state_nxt;
  logic [CntW-1:0]   cnt_r, cnt_nxt;
  logic              out_valid_r, out_valid_nxt;

  // generator words
  logic [WordW-1:0]  seed_r, seed_nxt;
  logic [WordW-1:0]  beef_r, beef_nxt;

  // remainder datapath
  logic [RangeW-1:0] range_r, range_nxt;
  logic [RangeW-1:0] dvd_r, dvd_nxt;
  logic [RangeW-1:0] rem_r, rem_nxt;
  drnd_out_t         out_data_r, out_data_nxt;

  logic              in_acc;
  logic              draw_acc;
  logic              stir_acc;
  logic              out_free;
  logic              load_out;
  logic [WordW-1:0]  seed_mixed;
  logic [WordW-1:0]  trial;
  logic [WordW-1:0]  diff;
  logic              fits;

  assign in_acc   = in_valid && !in_stall;
  assign draw_acc = in_acc && (in_data.action == ActDraw);
  assign stir_acc = in_acc && (in_data.action == ActStir);
  assign out_free = !out_valid_r || !out_stall;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (draw_acc) begin
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        if (cnt_r == DivLast) begin
          state_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // state decoded controls
  always_comb begin
    in_stall = 1'b1;
    load_out = 1'b0;
    case (state_r)
      ST_IDLE: in_stall = 1'b0;
      ST_DIV:  in_stall = 1'b1;
      ST_FIN:  load_out = out_free;
      default: in_stall = 1'b1;
    endcase
  end

  // one remainder step: shift in the next dividend bit, subtract if it fits
  assign trial = {rem_r, dvd_r[RangeW-1]};
  assign diff  = trial - {1'b0, range_r};
  assign fits  = trial >= {1'b0, range_r};

  assign seed_mixed = mix_word(seed_r, beef_r);

  // datapath next values
  always_comb begin
    seed_nxt      = seed_r;
    beef_nxt      = beef_r;
    range_nxt     = range_r;
    dvd_nxt       = dvd_r;
    rem_nxt       = rem_r;
    cnt_nxt       = cnt_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r;

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    if (stir_acc) begin
      seed_nxt = seed_r ^ (WordW'(1) << in_data.trash[CntW-1:0]);
    end

    if (draw_acc) begin
      // new seed goes straight into the dividend; beef advances now
      seed_nxt  = seed_mixed;
      beef_nxt  = mix_word(beef_r, BeefReset);
      range_nxt = in_data.range;
      dvd_nxt   = seed_mixed[RangeW-1:0];
      rem_nxt   = '0;
      cnt_nxt   = '0;
    end

    if (state_r == ST_DIV) begin
      rem_nxt = fits ? diff[RangeW-1:0] : trial[RangeW-1:0];
      dvd_nxt = {dvd_r[RangeW-2:0], 1'b0};
      cnt_nxt = cnt_r + CntW'(1);
    end

    if (load_out) begin
      out_valid_nxt            = 1'b1;
      out_data_nxt.range_error = (range_r == '0);
      out_data_nxt.value       = (range_r == '0) ? '0 : rem_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
      seed_r      <= SeedReset;
      beef_r      <= BeefReset;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
      seed_r      <= seed_nxt;
      beef_r      <= beef_nxt;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    range_r    <= range_nxt;
    dvd_r      <= dvd_nxt;
    rem_r      <= rem_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // an accepted draw always starts the remainder loop from step zero
  a_draw_starts: assert property (@(posedge clk) disable iff (!rst_n)
    draw_acc |=> (state_r == ST_DIV) && (cnt_r == '0))
    else $error("draw did not start the remainder loop");

  // after the last step the partial remainder is below a nonzero range
  a_rem_below: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FIN) && (range_r != '0) |-> (rem_r < range_r))
    else $error("remainder not reduced below range");

  // a new output beat only comes out of the final cycle of a draw
  a_out_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == ST_FIN))
    else $error("output beat without a finished draw");

  // a flagged beat carries a zero value
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r.range_error |-> (out_data_r.value == '0))
    else $error("range error with nonzero value");

endmodule
